// ===== rtl/core/lcd_pixel_framebuffer_bridge_assert.svh =====
// Assertion helpers shared by the bridge modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef LCD_PIXEL_FRAMEBUFFER_BRIDGE_ASSERT_SVH
`define LCD_PIXEL_FRAMEBUFFER_BRIDGE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define LPFB_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LPFB_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpfb_pkg.sv =====
package lpfb_pkg;

    // display geometry
    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int STORE_SIZE = COLUMNS * PAGES;
    localparam int IDX_W      = $clog2(STORE_SIZE);

    // field widths
    localparam int OPC_W  = 2;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int PAGE_W = ROW_W - 3;
    localparam int BYTE_W = 8;
    localparam int COFF_W = 3;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // bus commands
    localparam logic [BYTE_W-1:0] CMD_PAGE     = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_CONTRAST = 8'h81;

    localparam logic [COFF_W-1:0] COFF_RESET     = 3'd4;
    localparam logic [BYTE_W-1:0] CONTRAST_RESET = 8'd28;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_SET_PIXEL   = 2'd0,
        OP_CLEAR_PIXEL = 2'd1,
        OP_CONTRAST    = 2'd2,
        OP_RAW         = 2'd3
    } t_opcode;

    typedef enum logic [0:0] {
        REG_COLUMN_OFFSET   = 1'b0,
        REG_CONTRAST_OFFSET = 1'b1
    } t_reg;

    typedef enum logic [1:0] {
        K_PIXEL,
        K_CONTRAST,
        K_RAW
    } t_kind;

    typedef struct packed {
        logic [COFF_W-1:0] column_offset;
        logic [BYTE_W-1:0] contrast_offset;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef struct packed {
        t_kind              kind;
        logic               set;
        logic [2:0]         bitpos;
        logic [PAGE_W-1:0]  page;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  addr;
        logic [BYTE_W-1:0]  val;
    } t_job;

    function automatic logic [PTR_W-1:0] f_ptr_next(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/lpfb_if.sv =====
interface lpfb_in_if import lpfb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] value;

    modport source (output valid, opcode, column, row, value, input ready);
    modport sink   (input valid, opcode, column, row, value, output ready);
endinterface

interface lpfb_out_if import lpfb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] bus_byte;
    logic              is_data;
    logic              last;

    modport source (output valid, bus_byte, is_data, last, input ready);
    modport sink   (input valid, bus_byte, is_data, last, output ready);
endinterface

// ===== rtl/core/lcd_pixel_framebuffer_bridge.sv =====
// Shadow framebuffer and bus sequencer for a 128x64 page-organized mono LCD.
// Words in on i_cmd: set pixel, clear pixel, set contrast, raw data byte.
// Words out on o_bus: LCD bus bytes with register select (is_data) and a
// last flag on the final byte of each command. A pixel command updates the
// byte that holds the pixel and emits page, column-high, column-low and the
// new data byte; contrast emits 0x81 then level+offset; raw passes one byte.
// Pixel commands outside the panel are accepted and produce nothing.
// After reset all COLUMNS*PAGES = 1024 store bytes are swept to zero with
// i_cmd.ready low; config writes still work. After that a pixel is one
// read-modify-write on the single-port store, then four bus words through
// the output register. A two-entry queue between the decode and sequencer
// lets i_cmd keep accepting while o_bus is stalled, until the queue fills.
// Registers: 0x0 column_offset[2:0] (reset 4), 0x4 contrast_offset[7:0]
// (reset 28); write only while idle.

module lcd_pixel_framebuffer_bridge import lpfb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command words
    lpfb_in_if.sink            i_cmd,
    // LCD bus words
    lpfb_out_if.source         o_bus,
    // APB config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg       r_cfg;
    t_back_stat w_stat;
    t_job       w_push_job;
    t_job       w_head_job;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_avail;
    logic       w_wr_en;

    // ---- config registers ----
    assign pready  = 1'b1;
    assign w_wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_offset   <= COFF_RESET;
            r_cfg.contrast_offset <= CONTRAST_RESET;
        end else if (w_wr_en) begin
            unique case (t_reg'(paddr[2]))
                REG_COLUMN_OFFSET:   r_cfg.column_offset   <= pwdata[COFF_W-1:0];
                REG_CONTRAST_OFFSET: r_cfg.contrast_offset <= pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_COLUMN_OFFSET:   prdata = PDATA_W'(r_cfg.column_offset);
            REG_CONTRAST_OFFSET: prdata = PDATA_W'(r_cfg.contrast_offset);
            default:             prdata = '0;
        endcase
    end

    // ---- decode: classify, range-check, resolve addresses ----
    lpfb_front u_front (
        .i_cmd  (i_cmd),
        .i_cfg  (r_cfg),
        .i_stat (w_stat),
        .i_full (w_full),
        .o_push (w_push),
        .o_job  (w_push_job)
    );

    // ---- decoupling queue ----
    lpfb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_avail (w_avail),
        .o_data  (w_head_job)
    );

    // ---- sequencer: store sweep, read-modify-write, bus words ----
    lpfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_stat  (w_stat),
        .o_bus   (o_bus)
    );

endmodule

// ===== rtl/core/lpfb_front.sv =====
module lpfb_front import lpfb_pkg::*; (
    lpfb_in_if.sink    i_cmd,
    input  t_cfg       i_cfg,
    input  t_back_stat i_stat,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [PAGE_W-1:0] w_page;
    logic              w_keep;

    assign w_page      = i_cmd.row[ROW_W-1:3];
    assign i_cmd.ready = !i_full && !i_stat.clearing;
    assign o_push      = i_cmd.valid && i_cmd.ready && w_keep;

    always_comb begin
        o_job.kind   = K_PIXEL;
        o_job.set    = 1'b1;
        o_job.bitpos = i_cmd.row[2:0];
        o_job.page   = w_page;
        o_job.idx    = IDX_W'(int'(w_page) * COLUMNS + int'(i_cmd.column));
        o_job.addr   = BYTE_W'(i_cmd.column) + BYTE_W'(i_cfg.column_offset);
        o_job.val    = i_cmd.value;
        // off-panel pixels are swallowed
        w_keep       = (int'(i_cmd.column) < COLUMNS) && (int'(w_page) < PAGES);
        unique case (t_opcode'(i_cmd.opcode))
            OP_SET_PIXEL: begin
                o_job.set = 1'b1;
            end
            OP_CLEAR_PIXEL: begin
                o_job.set = 1'b0;
            end
            OP_CONTRAST: begin
                o_job.kind = K_CONTRAST;
                o_job.val  = i_cmd.value + i_cfg.contrast_offset;
                w_keep     = 1'b1;
            end
            OP_RAW: begin
                o_job.kind = K_RAW;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lpfb_fifo.sv =====
`include "lcd_pixel_framebuffer_bridge_assert.svh"

module lpfb_fifo import lpfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_avail,
    output t_job o_data
);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `LPFB_CHECK(a_no_overflow, !(i_push && o_full), "push into full queue")
    `LPFB_CHECK(a_no_underflow, !(i_pop && !o_avail), "pop from empty queue")
    `LPFB_CHECK(a_cnt_bound, r_cnt <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/core/lpfb_back.sv =====
`include "lcd_pixel_framebuffer_bridge_assert.svh"

module lpfb_back import lpfb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_job        i_job,
    output logic        o_pop,
    output t_back_stat  o_stat,
    lpfb_out_if.source  o_bus
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_clr;
    t_job              r_job;
    logic [1:0]        r_step;
    logic [BYTE_W-1:0] r_rdata;
    logic [BYTE_W-1:0] r_data;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_is_data;
    logic              r_out_last;

    logic [BYTE_W-1:0] r_mem [STORE_SIZE];

    logic              w_slot_free;
    logic              w_load;
    logic              w_last_step;
    logic              w_take;
    logic [BYTE_W-1:0] w_mask;
    logic [BYTE_W-1:0] w_new;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic [BYTE_W-1:0] w_byte;
    logic              w_is_data;

    assign o_bus.valid    = r_out_valid;
    assign o_bus.bus_byte = r_out_byte;
    assign o_bus.is_data  = r_out_is_data;
    assign o_bus.last     = r_out_last;

    assign o_stat.clearing = (r_state == S_CLEAR);

    assign w_slot_free = !r_out_valid || o_bus.ready;
    // output register takes a new word this cycle
    assign w_load      = (r_state == S_EMIT) && w_slot_free;
    assign w_take      = (r_state == S_IDLE)
                      || (r_state == S_EMIT && w_slot_free && w_last_step);
    assign o_pop       = w_take && i_avail;

    assign w_mask = BYTE_W'(1) << r_job.bitpos;
    assign w_new  = r_job.set ? (r_rdata | w_mask) : (r_rdata & ~w_mask);

    // one write port: sweep after reset, else the read-modify-write
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_RMW);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_job.idx;
    assign w_wdata = (r_state == S_CLEAR) ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[i_job.idx];
        end
    end

    always_comb begin
        w_last_step = 1'b1;
        w_byte      = r_job.val;
        w_is_data   = 1'b1;
        unique case (r_job.kind)
            K_PIXEL: begin
                w_last_step = (r_step == 2'd3);
                w_is_data   = 1'b0;
                unique case (r_step)
                    2'd0: w_byte = CMD_PAGE | BYTE_W'(r_job.page);
                    2'd1: w_byte = CMD_COL_HIGH | BYTE_W'(r_job.addr[7:4]);
                    2'd2: w_byte = BYTE_W'(r_job.addr[3:0]);
                    default: begin
                        w_byte    = r_data;
                        w_is_data = 1'b1;
                    end
                endcase
            end
            K_CONTRAST: begin
                w_last_step = (r_step == 2'd1);
                w_is_data   = 1'b0;
                w_byte      = (r_step == 2'd0) ? CMD_CONTRAST : r_job.val;
            end
            default: begin
                w_last_step = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_bus.ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_job   <= i_job;
                r_step  <= '0;
                r_state <= (i_job.kind == K_PIXEL) ? S_RMW : S_EMIT;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(STORE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                end
                S_RMW: begin
                    r_data  <= w_new;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_byte    <= w_byte;
                        r_out_is_data <= w_is_data;
                        r_out_last    <= w_last_step;
                        if (!w_last_step) begin
                            r_step <= r_step + 2'd1;
                        end else if (!i_avail) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `LPFB_CHECK(a_quiet_clear, !(r_state == S_CLEAR && r_out_valid), "output during clear")
    `LPFB_CHECK(a_data_is_last, !(r_out_valid && r_out_is_data && !r_out_last),
        "data word not last")
    `LPFB_CHECK_NEXT(a_rmw_then_emit, r_state == S_RMW, r_state == S_EMIT && r_step == 2'd0,
        "rmw not followed by first word")

endmodule

// ===== bench/tb_lcd_pixel_framebuffer_bridge.sv =====
module tb_lcd_pixel_framebuffer_bridge import lpfb_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either channel before we give up. The
    // longest quiet stretch in a good run is the post-reset store sweep,
    // well under this.
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam logic [BYTE_W-1:0] COL_LOW_MASK = 8'h0F;

    // One command word as the sender sees it.
    typedef struct packed {
        t_opcode           op;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [BYTE_W-1:0] value;
    } t_cmd;

    // One LCD bus word: byte, register select, end-of-command flag.
    typedef struct packed {
        logic [BYTE_W-1:0] bus_byte;
        logic              is_data;
        logic              last;
    } t_bus_word;

    localparam logic [9:0] NIL = '0;

    // Directed row: either a register reload or one command word. When
    // n_typed is nonzero the bus words are spelled out in the row,
    // otherwise the shadow model supplies them.
    typedef struct {
        bit                  reconf;
        logic [COFF_W-1:0]   coff;
        logic [BYTE_W-1:0]   ctoff;
        t_cmd                word;
        int                  n_typed;
        logic [0:3][9:0]     typed;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lpfb_in_if  cmd_if ();
    lpfb_out_if bus_if ();

    lcd_pixel_framebuffer_bridge dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_bus   (bus_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the panel store and of the two offset registers.
    logic [BYTE_W-1:0] shadow_fb [STORE_SIZE];
    logic [COFF_W-1:0] coff_q;
    logic [BYTE_W-1:0] ctoff_q;

    // Bus words still owed by the block, oldest first.
    t_bus_word bus_bytes_due [$];

    int  n_bad       = 0;
    int  idle_cycles = 0;
    int  hold_left   = 0;   // >0 asks the bus side for a long hold-off
    bit  send_gaps   = 1'b1;
    bit  recv_stalls = 1'b1;

    t_dir_row dir_tab [$];

    // ------------------------------------------------------------------
    // Shadow model: applies one command to the store and works out the
    // bus words it should produce.
    // ------------------------------------------------------------------
    function automatic void predict_bus_bytes(input t_cmd c, output t_bus_word w [4],
                                              output int n);
        logic [PAGE_W-1:0] page;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] fb;
        int                idx;
        n = 0;
        foreach (w[k]) w[k] = '0;
        case (c.op)
            OP_SET_PIXEL, OP_CLEAR_PIXEL: begin
                page = c.row[ROW_W-1:3];
                // off-panel pixels are swallowed silently
                if (int'(c.column) < COLUMNS && int'(page) < PAGES) begin
                    idx = int'(page) * COLUMNS + int'(c.column);
                    fb  = shadow_fb[idx];
                    fb[c.row[2:0]] = (c.op == OP_SET_PIXEL);
                    shadow_fb[idx] = fb;
                    // column address wraps at 8 bits
                    addr = BYTE_W'(c.column) + BYTE_W'(coff_q);
                    w[0] = '{CMD_PAGE | BYTE_W'(page), 1'b0, 1'b0};
                    w[1] = '{CMD_COL_HIGH | (addr >> 4), 1'b0, 1'b0};
                    w[2] = '{addr & COL_LOW_MASK, 1'b0, 1'b0};
                    w[3] = '{fb, 1'b1, 1'b1};
                    n = 4;
                end
            end
            OP_CONTRAST: begin
                w[0] = '{CMD_CONTRAST, 1'b0, 1'b0};
                w[1] = '{c.value + ctoff_q, 1'b0, 1'b1};
                n = 2;
            end
            default: begin
                w[0] = '{c.value, 1'b1, 1'b1};
                n = 1;
            end
        endcase
    endfunction

    // Shorthands for typed bus words in the directed table.
    function automatic logic [9:0] cmd(input logic [BYTE_W-1:0] b);
        return {b, 1'b0, 1'b0};
    endfunction

    function automatic logic [9:0] cmd_end(input logic [BYTE_W-1:0] b);
        return {b, 1'b0, 1'b1};
    endfunction

    function automatic logic [9:0] data_end(input logic [BYTE_W-1:0] b);
        return {b, 1'b1, 1'b1};
    endfunction

    function automatic t_dir_row step(input t_opcode op, input int col, input int row,
                                      input int val, input int n,
                                      input logic [0:3][9:0] t);
        t_dir_row r;
        r.reconf  = 1'b0;
        r.coff    = '0;
        r.ctoff   = '0;
        r.word    = '{op, COL_W'(col), ROW_W'(row), BYTE_W'(val)};
        r.n_typed = n;
        r.typed   = t;
        return r;
    endfunction

    function automatic t_dir_row regs(input int coff, input int ctoff);
        t_dir_row r;
        r.reconf  = 1'b1;
        r.coff    = COFF_W'(coff);
        r.ctoff   = BYTE_W'(ctoff);
        r.word    = '0;
        r.n_typed = 0;
        r.typed   = '0;
        return r;
    endfunction

    // Random command, mostly pixel ops. Half of the pixels land in a small
    // corner so bytes get several bits set and cleared over time.
    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            c.op = t_opcode'($urandom_range(0, 1));
        end else if (pick < 8) begin
            c.op = OP_CONTRAST;
        end else begin
            c.op = OP_RAW;
        end
        if ($urandom_range(0, 1) == 0) begin
            c.column = COL_W'($urandom_range(0, 3));
            c.row    = ROW_W'($urandom_range(0, 15));
        end else begin
            c.column = COL_W'($urandom_range(0, (1 << COL_W) - 1));
            c.row    = ROW_W'($urandom_range(0, (1 << ROW_W) - 1));
        end
        c.value = BYTE_W'($urandom_range(0, 255));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Config port: setup cycle, then access until pready; the register
    // takes the value at the access edge.
    // ------------------------------------------------------------------
    task automatic apb_write(input t_reg r, input logic [PDATA_W-1:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({r, 2'b00});
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_COLUMN_OFFSET:   coff_q  = d[COFF_W-1:0];
            REG_CONTRAST_OFFSET: ctoff_q = d[BYTE_W-1:0];
        endcase
    endtask

    // Drop valid, let every owed word come out, then load both offsets.
    // Upper pwdata bits carry junk the block must ignore.
    task automatic reload_regs(input logic [COFF_W-1:0] coff, input logic [BYTE_W-1:0] ctoff);
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (bus_bytes_due.size() != 0);
        apb_write(REG_COLUMN_OFFSET, ($urandom() & ~32'h7) | PDATA_W'(coff));
        apb_write(REG_CONTRAST_OFFSET, ($urandom() & ~32'hFF) | PDATA_W'(ctoff));
    endtask

    // Offer one command word and hold it until taken. Valid is left high
    // unless a gap is drawn, so back-to-back words need no re-raise.
    task automatic send_word(input t_cmd c, input int n_typed, input logic [0:3][9:0] typed);
        t_bus_word w [4];
        int        n;
        cmd_if.valid  <= 1'b1;
        cmd_if.opcode <= c.op;
        cmd_if.column <= c.column;
        cmd_if.row    <= c.row;
        cmd_if.value  <= c.value;
        do @(posedge i_clk); while (!cmd_if.ready);
        // taken at this edge: store update happens even for typed rows
        predict_bus_bytes(c, w, n);
        if (n_typed > 0) begin
            for (int k = 0; k < n_typed; k++) bus_bytes_due.push_back(t_bus_word'(typed[k]));
        end else begin
            for (int k = 0; k < n; k++) bus_bytes_due.push_back(w[k]);
        end
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Bus side: ready with random stall bursts, plus the long hold-off
    // that backs the block up into its command queue.
    // ------------------------------------------------------------------
    initial begin : bus_sink
        int n;
        bus_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                bus_if.ready <= 1'b0;
                repeat (hold_left) @(posedge i_clk);
                hold_left = 0;
                bus_if.ready <= 1'b1;
            end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                bus_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
                bus_if.ready <= 1'b1;
            end
        end
    end

    // Checker: every bus word taken is matched against the oldest owed one.
    always @(posedge i_clk) begin
        t_bus_word got;
        t_bus_word want;
        if (i_rst_n && bus_if.valid && bus_if.ready) begin
            got = '{bus_if.bus_byte, bus_if.is_data, bus_if.last};
            if (bus_bytes_due.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_MAX) begin
                    $display("%0t ns: unexpected bus word byte %h is_data %b last %b",
                             $realtime, got.bus_byte, got.is_data, got.last);
                end
            end else begin
                want = bus_bytes_due.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= REPORT_MAX) begin
                        $display({"%0t ns: bus word mismatch: expected byte %h is_data %b ",
                                  "last %b, got byte %h is_data %b last %b"},
                                 $realtime, want.bus_byte, want.is_data, want.last,
                                 got.bus_byte, got.is_data, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: counts edges where neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (bus_if.valid && bus_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d bus words still owed",
                     STALL_LIMIT, bus_bytes_due.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        cmd_if.valid  <= 1'b0;
        cmd_if.opcode <= OP_SET_PIXEL;
        cmd_if.column <= '0;
        cmd_if.row    <= '0;
        cmd_if.value  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        foreach (shadow_fb[i]) shadow_fb[i] = '0;
        coff_q  = COFF_RESET;
        ctoff_q = CONTRAST_RESET;

        // Reset values first (offsets 4 and 28), then the register
        // extremes. Typed rows can be read straight off the spec.
        dir_tab = '{
            step(OP_RAW,         0,   0, 8'h00, 1, {data_end(8'h00), NIL, NIL, NIL}),
            step(OP_RAW,         0,   0, 8'hFF, 1, {data_end(8'hFF), NIL, NIL, NIL}),
            step(OP_CONTRAST,    0,   0, 8'h00, 2, {cmd(8'h81), cmd_end(8'h1C), NIL, NIL}),
            // 255 + 28 wraps to 27
            step(OP_CONTRAST,    0,   0, 8'hFF, 2, {cmd(8'h81), cmd_end(8'h1B), NIL, NIL}),
            step(OP_SET_PIXEL,   0,   0, 0,     4,
                 {cmd(8'hB0), cmd(8'h10), cmd(8'h04), data_end(8'h01)}),
            step(OP_SET_PIXEL,   0,   7, 0,     4,
                 {cmd(8'hB0), cmd(8'h10), cmd(8'h04), data_end(8'h81)}),
            step(OP_CLEAR_PIXEL, 0,   0, 0,     4,
                 {cmd(8'hB0), cmd(8'h10), cmd(8'h04), data_end(8'h80)}),
            // far corner: column 127 + 4 = 0x83
            step(OP_SET_PIXEL,   127, 63, 0,    4,
                 {cmd(8'hB7), cmd(8'h18), cmd(8'h03), data_end(8'h80)}),
            step(OP_CLEAR_PIXEL, 127, 63, 8'hFF, 4,
                 {cmd(8'hB7), cmd(8'h18), cmd(8'h03), data_end(8'h00)}),
            // clearing an already-empty byte, unused fields driven high
            step(OP_CLEAR_PIXEL, 5,   20, 8'hFF, 0, '0),
            step(OP_SET_PIXEL,   124, 32, 8'hFF, 0, '0),
            step(OP_CONTRAST,    127, 63, 8'h80, 0, '0),
            step(OP_RAW,         127, 63, 8'h5A, 0, '0),
            step(OP_SET_PIXEL,   60,  45, 8'h55, 0, '0),
            step(OP_SET_PIXEL,   60,  44, 8'hAA, 0, '0),
            // column offset past four, contrast offset at its top
            regs(7, 255),
            step(OP_SET_PIXEL,   127, 8,  0,    4,
                 {cmd(8'hB1), cmd(8'h18), cmd(8'h06), data_end(8'h01)}),
            step(OP_CONTRAST,    0,   0,  8'h01, 2, {cmd(8'h81), cmd_end(8'h00), NIL, NIL}),
            step(OP_CONTRAST,    0,   0,  8'h00, 2, {cmd(8'h81), cmd_end(8'hFF), NIL, NIL}),
            step(OP_SET_PIXEL,   121, 9,  0,    0, '0),
            // both offsets at zero
            regs(0, 0),
            step(OP_SET_PIXEL,   0,   56, 0,    4,
                 {cmd(8'hB7), cmd(8'h10), cmd(8'h00), data_end(8'h01)}),
            step(OP_CONTRAST,    0,   0,  8'hAB, 2, {cmd(8'h81), cmd_end(8'hAB), NIL, NIL}),
            step(OP_CLEAR_PIXEL, 0,   56, 0,    4,
                 {cmd(8'hB7), cmd(8'h10), cmd(8'h00), data_end(8'h00)})
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its store after reset with ready low; the first
        // word simply waits for it.
        foreach (dir_tab[i]) begin
            if (dir_tab[i].reconf) begin
                reload_regs(dir_tab[i].coff, dir_tab[i].ctoff);
            end else begin
                send_word(dir_tab[i].word, dir_tab[i].n_typed, dir_tab[i].typed);
            end
        end

        // Random phases, each under fresh offsets.
        for (int ph = 0; ph < 4; ph++) begin
            reload_regs(COFF_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)));
            if (ph == 1) begin
                // Long bus hold-off while commands keep coming back to back:
                // the queue fills and i_cmd must stall.
                hold_left = 80;
                send_gaps = 1'b0;
                repeat (16) send_word(rand_cmd(), 0, '0);
                send_gaps = 1'b1;
                repeat (9) send_word(rand_cmd(), 0, '0);
            end else begin
                repeat (25) send_word(rand_cmd(), 0, '0);
            end
        end

        // Tail: no idling on either side, offsets back at reset values.
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        reload_regs(COFF_RESET, CONTRAST_RESET);
        repeat (30) send_word(rand_cmd(), 0, '0);

        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (bus_bytes_due.size() != 0);
        // give stray output time to show up
        repeat (20) @(posedge i_clk);

        if (n_bad == 0 && bus_bytes_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
